@@ rtl/core/led_strip_meteor_serializer_top_assert.svh @@
// Assertion macros for the LED strip meteor serializer
`ifndef LED_STRIP_METEOR_SERIALIZER_TOP_ASSERT_SVH
`define LED_STRIP_METEOR_SERIALIZER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define LSMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsms: same-cycle check failed");

// Check a consequence in the cycle after its antecedent
`define LSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsms: next-cycle check failed");

`endif

@@ rtl/core/lsms_pkg.sv @@
// Shared types and constants of the LED strip meteor serializer
package lsms_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd7;

   // effect modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_BLINK  = 2'd1;
   localparam logic [1:0] MODE_METEOR = 2'd2;

   localparam logic [1:0] MODE_RESET = MODE_METEOR;
   localparam logic [5:0] ZERO_HIGH_RESET = 6'd4;
   localparam logic [5:0] ZERO_LOW_RESET  = 6'd9;
   localparam logic [5:0] ONE_HIGH_RESET  = 6'd8;
   localparam logic [5:0] ONE_LOW_RESET   = 6'd5;

   localparam int BITS_PER_LED = 24;
   localparam int BIT_CNT_W    = 5;

   // effect settings; the quotients are colour divided by the tail length
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] red_quot;
      logic [7:0] green_quot;
      logic [7:0] blue_quot;
   } lsms_effect_type;

   // line code timing
   typedef struct packed {
      logic [5:0] zero_high;
      logic [5:0] zero_low;
      logic [5:0] one_high;
      logic [5:0] one_low;
   } lsms_slots_type;

   // one LED worth of work: colour in send order and the last-LED flag
   typedef struct packed {
      logic [BITS_PER_LED-1:0] grb;
      logic                    last_led;
   } lsms_entry_type;

endpackage

@@ rtl/core/lsms_if.sv @@
// Handshake channel interfaces of the LED strip meteor serializer
interface lsms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bg_red;
   logic [7:0] bg_green;
   logic [7:0] bg_blue;

   modport source (output valid, output bg_red, output bg_green, output bg_blue,
                   input ready);
   modport sink   (input valid, input bg_red, input bg_green, input bg_blue,
                   output ready);
endinterface

interface lsms_rsp_if;
   logic       valid;
   logic       ready;
   logic       bit_value;
   logic [5:0] high_slots;
   logic [5:0] low_slots;
   logic       last_bit;
   logic       frame_end;

   modport source (output valid, output bit_value, output high_slots, output low_slots,
                   output last_bit, output frame_end, input ready);
   modport sink   (input valid, input bit_value, input high_slots, input low_slots,
                   input last_bit, input frame_end, output ready);
endinterface

@@ rtl/core/lsms_front.sv @@
// Front end: accepts LED items, picks the colour and tracks frame position
module lsms_front #(
   parameter int LED_COUNT   = 64,
   parameter int TAIL_LENGTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   lsms_req_if.sink                 req_chan,
   input  lsms_pkg::lsms_effect_type effect,
   output logic                     push_valid,
   input  logic                     push_ready,
   output lsms_pkg::lsms_entry_type  push_data
);
   import lsms_pkg::*;

   localparam int SPAN = LED_COUNT + TAIL_LENGTH - 1;
   localparam int LW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int HW   = (SPAN > 1) ? $clog2(SPAN) : 1;
   localparam int DW   = (TAIL_LENGTH > 1) ? $clog2(TAIL_LENGTH) : 1;
   localparam int CW   = ((LW > HW) ? LW : HW) + 1;

   logic [LW-1:0] led_pos_ff, led_pos_in;
   logic [HW-1:0] head_ff, head_in;
   logic          phase_ff, phase_in;

   logic          accept;
   logic          active;
   logic          last_led;
   logic          in_tail;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] head_ext;
   logic [CW-1:0] lag;
   logic [DW-1:0] lag_d;
   logic [7:0]    send_red, send_green, send_blue;

   // c - d * (c / tail), with the quotient already held in the effect settings
   function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] quot,
                                              input logic [DW-1:0] d);
      logic [DW+7:0] prod;
      prod = (DW+8)'(d) * (DW+8)'(quot);
      return c - prod[7:0];
   endfunction

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;
   assign active = (effect.mode == MODE_BLINK) || (effect.mode == MODE_METEOR);

   // classify the slot against the meteor tail
   assign pos_ext  = CW'(led_pos_ff);
   assign head_ext = CW'(head_ff);
   assign lag      = head_ext - pos_ext;
   assign lag_d    = lag[DW-1:0];
   assign in_tail  = (pos_ext <= head_ext) && (lag <= CW'(TAIL_LENGTH - 1));
   assign last_led = (led_pos_ff == LW'(LED_COUNT - 1));

   // choose the colour to send
   always_comb begin
      if (effect.mode == MODE_BLINK) begin
         send_red   = phase_ff ? effect.red   : 8'd0;
         send_green = phase_ff ? effect.green : 8'd0;
         send_blue  = phase_ff ? effect.blue  : 8'd0;
      end else if (in_tail) begin
         send_red   = dim_channel(effect.red,   effect.red_quot,   lag_d);
         send_green = dim_channel(effect.green, effect.green_quot, lag_d);
         send_blue  = dim_channel(effect.blue,  effect.blue_quot,  lag_d);
      end else begin
         send_red   = req_chan.bg_red;
         send_green = req_chan.bg_green;
         send_blue  = req_chan.bg_blue;
      end
   end

   assign push_valid         = req_chan.valid && active;
   assign push_data.grb      = {send_green, send_red, send_blue};
   assign push_data.last_led = last_led;

   // advance position, then head or blink phase at the end of a frame
   always_comb begin
      led_pos_in = led_pos_ff;
      head_in    = head_ff;
      phase_in   = phase_ff;
      if (accept && active) begin
         if (last_led) begin
            led_pos_in = '0;
            if (effect.mode == MODE_METEOR) begin
               head_in = (head_ff == HW'(SPAN - 1)) ? '0 : head_ff + 1'b1;
            end else begin
               phase_in = ~phase_ff;
            end
         end else begin
            led_pos_in = led_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_pos_ff <= '0;
         head_ff    <= '0;
         phase_ff   <= 1'b0;
      end else begin
         led_pos_ff <= led_pos_in;
         head_ff    <= head_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

@@ rtl/core/lsms_queue.sv @@
// Two-entry queue between the front end and the bit serializer
module lsms_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  lsms_pkg::lsms_entry_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output lsms_pkg::lsms_entry_type pop_data
);
   import lsms_pkg::*;

   lsms_entry_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   logic           pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // move pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/lsms_back.sv @@
// Back end: serializes one queued LED into 24 pulse transactions
module lsms_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  lsms_pkg::lsms_entry_type pop_data,
   input  lsms_pkg::lsms_slots_type slots,
   lsms_rsp_if.source               rsp_chan
);
   import lsms_pkg::*;

   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 valid_ff, valid_in;
   logic                 bit_ff, bit_in;
   logic [5:0]           high_ff, high_in;
   logic [5:0]           low_ff, low_in;
   logic                 last_ff, last_in;
   logic                 frame_end_ff, frame_end_in;
   logic                 load;
   logic                 last_of_led;

   // load a new pulse when the output register is free or being taken
   assign load        = pop_valid && (!valid_ff || rsp_chan.ready);
   assign last_of_led = (bit_cnt_ff == BIT_CNT_W'(BITS_PER_LED - 1));
   assign pop_ready   = load && last_of_led;

   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      valid_in     = valid_ff && !rsp_chan.ready;
      bit_in       = bit_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      last_in      = last_ff;
      frame_end_in = frame_end_ff;
      if (load) begin
         valid_in     = 1'b1;
         bit_in       = pop_data.grb[BIT_CNT_W'(BITS_PER_LED - 1) - bit_cnt_ff];
         high_in      = bit_in ? slots.one_high : slots.zero_high;
         low_in       = bit_in ? slots.one_low  : slots.zero_low;
         last_in      = last_of_led;
         frame_end_in = last_of_led && pop_data.last_led;
         bit_cnt_in   = last_of_led ? '0 : bit_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         valid_ff   <= valid_in;
      end
   end

   // hold the pulse payload
   always_ff @(posedge clock) begin
      bit_ff       <= bit_in;
      high_ff      <= high_in;
      low_ff       <= low_in;
      last_ff      <= last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.bit_value  = bit_ff;
   assign rsp_chan.high_slots = high_ff;
   assign rsp_chan.low_slots  = low_ff;
   assign rsp_chan.last_bit   = last_ff;
   assign rsp_chan.frame_end  = frame_end_ff;

endmodule

@@ rtl/core/led_strip_meteor_serializer_top.sv @@
// Top level of the LED strip meteor serializer: settings registers and channel wiring
// Usage:
//  req_chan takes one transaction per LED slot carrying its background colour.
//  rsp_chan gives 24 pulse transactions per LED, green, red, blue, MSB first,
//  each with the bit and its high and low slot counts; last_bit marks the
//  24th pulse of an LED and frame_end that of the last LED of the frame.
//  In off mode (or the unused mode code) a request is taken and dropped.
//  csr_wr_en / csr_index / csr_wdata write the settings; write only when idle.
// Timing:
//  With the serializer idle, a request taken is written into a queue entry
//  and the first pulse of its LED then into the output register.
//  The serializer emits one pulse per cycle while rsp_chan is ready, and
//  the front end computes the colour in the accepting cycle; a two-entry queue
//  lets it take the next requests while the serializer is busy.
// Reset and stalls:
//  Synchronous reset clears position, head, blink phase, queue and output
//  register and restores the setting defaults (meteor mode, black colour).
//  When rsp_chan stalls the pulse output holds, the queue fills and
//  req_chan.ready drops once both queue entries are occupied.
`include "led_strip_meteor_serializer_top_assert.svh"

module led_strip_meteor_serializer_top #(
   parameter int LED_COUNT   = 64,
   parameter int TAIL_LENGTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   lsms_req_if.sink                           req_chan,
   lsms_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [lsms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsms_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsms_pkg::*;

   // reciprocal of the tail length, exact floor for any 8-bit colour
   localparam int          RECIP_SHIFT = 16;
   localparam logic [16:0] RECIP = 17'(((1 << RECIP_SHIFT) + TAIL_LENGTH - 1) / TAIL_LENGTH);

   lsms_effect_type effect_ff, effect_in;
   lsms_slots_type  slots_ff, slots_in;

   logic [24:0]     quot_prod;
   logic [7:0]      wdata_quot;

   logic            push_valid;
   logic            push_ready;
   lsms_entry_type  push_data;
   logic            pop_valid;
   logic            pop_ready;
   lsms_entry_type  pop_data;

   // divide the written colour by the tail length
   assign quot_prod  = 25'(csr_wdata) * 25'(RECIP);
   assign wdata_quot = quot_prod[RECIP_SHIFT +: 8];

   // decode settings writes
   always_comb begin
      effect_in = effect_ff;
      slots_in  = slots_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE: begin
               effect_in.mode = csr_wdata[1:0];
            end
            CSR_RED: begin
               effect_in.red      = csr_wdata;
               effect_in.red_quot = wdata_quot;
            end
            CSR_GREEN: begin
               effect_in.green      = csr_wdata;
               effect_in.green_quot = wdata_quot;
            end
            CSR_BLUE: begin
               effect_in.blue      = csr_wdata;
               effect_in.blue_quot = wdata_quot;
            end
            CSR_ZERO_HIGH: slots_in.zero_high = csr_wdata[5:0];
            CSR_ZERO_LOW:  slots_in.zero_low  = csr_wdata[5:0];
            CSR_ONE_HIGH:  slots_in.one_high  = csr_wdata[5:0];
            CSR_ONE_LOW:   slots_in.one_low   = csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_ff.mode       <= MODE_RESET;
         effect_ff.red        <= 8'd0;
         effect_ff.green      <= 8'd0;
         effect_ff.blue       <= 8'd0;
         effect_ff.red_quot   <= 8'd0;
         effect_ff.green_quot <= 8'd0;
         effect_ff.blue_quot  <= 8'd0;
         slots_ff.zero_high   <= ZERO_HIGH_RESET;
         slots_ff.zero_low    <= ZERO_LOW_RESET;
         slots_ff.one_high    <= ONE_HIGH_RESET;
         slots_ff.one_low     <= ONE_LOW_RESET;
      end else begin
         effect_ff <= effect_in;
         slots_ff  <= slots_in;
      end
   end

   lsms_front #(
      .LED_COUNT   (LED_COUNT),
      .TAIL_LENGTH (TAIL_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .effect     (effect_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lsms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lsms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .slots     (slots_ff),
      .rsp_chan  (rsp_chan)
   );

   // frame end only ever falls on the closing pulse of an LED
   `LSMS_ASSERT_NOW(a_frame_end_last, clock, reset, rsp_chan.valid && rsp_chan.frame_end, rsp_chan.last_bit)
   // slot counts follow the bit sent
   `LSMS_ASSERT_NOW(a_slots_match, clock, reset, rsp_chan.valid && !csr_wr_en && !$past(csr_wr_en), rsp_chan.high_slots == (rsp_chan.bit_value ? slots_ff.one_high : slots_ff.zero_high))
   // a request taken in an active mode leaves work queued
   `LSMS_ASSERT_NEXT(a_push_queues, clock, reset, push_valid && push_ready, pop_valid)

endmodule

@@ bench/led_strip_meteor_serializer_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the LED strip meteor serializer: directed table and random phases
module led_strip_meteor_serializer_top_test;
   import lsms_pkg::*;

   localparam int LED_COUNT    = 64;
   localparam int TAIL_LENGTH  = 8;
   localparam int HEAD_SPAN    = LED_COUNT + TAIL_LENGTH - 1;
   localparam int SETTLE_TICKS = 8;
   localparam int RANDOM_LEDS  = 170;

   // mode code the block treats like off
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef enum logic {ROW_CSR, ROW_LED} row_kind_type;
   typedef enum logic [1:0] {FLOW_FREE, FLOW_SPARSE, FLOW_PERIODIC, FLOW_HEAVY} flow_style_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [7:0]            bg_red;
      logic [7:0]            bg_green;
      logic [7:0]            bg_blue;
      logic                  typed;
      logic [23:0]           grb;
   } script_row_type;

   typedef struct packed {
      logic       bit_value;
      logic [5:0] high_slots;
      logic [5:0] low_slots;
      logic       last_bit;
      logic       frame_end;
   } pulse_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lsms_req_if req_chan();
   lsms_rsp_if rsp_chan();

   // shadow of the settings and the frame state
   logic [1:0]  eff_mode;
   logic [7:0]  eff_red, eff_green, eff_blue;
   logic [5:0]  zero_high, zero_low, one_high, one_low;
   int unsigned led_pos, head_pos;
   logic        blink_on;

   pulse_type   pulse_queue[$];
   int unsigned fail_count;
   int unsigned burst_left;
   int unsigned lit_leds;

   // directed rows: kind, index, data, bg red/green/blue, typed, expected GRB
   script_row_type script [42] = '{
      // straight after reset: head and LED 0 coincide, colour black
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff},
      '{ROW_LED, CSR_MODE,      8'h00, 8'ha5, 8'h5a, 8'hc3, 1'b1, 24'h5aa5c3},
      // colour and slot extremes, upper data bits set
      '{ROW_CSR, CSR_RED,       8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_GREEN,     8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_BLUE,      8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ZERO_HIGH, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ZERO_LOW,  8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_HIGH,  8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_LOW,   8'hc1, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h12, 8'h34, 8'h56, 1'b1, 24'h341256},
      // blink starts on a black frame
      '{ROW_CSR, CSR_MODE,      8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h5a, 8'h5a, 8'h5a, 1'b1, 24'h000000},
      // off and the spare mode code drop the request
      '{ROW_CSR, CSR_MODE,      8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'hff, 8'hff, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_MODE,      8'h03, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'haa, 8'h55, 8'haa, 1'b0, 24'h000000},
      // zero slot counts pass straight through
      '{ROW_CSR, CSR_ZERO_HIGH, 8'hc0, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ZERO_LOW,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_HIGH,  8'h40, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_LOW,   8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_MODE,      8'hfe, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff},
      // back to the default timing, fresh colour, predictor checked
      '{ROW_CSR, CSR_ZERO_HIGH, 8'h04, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ZERO_LOW,  8'h09, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_HIGH,  8'h08, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_ONE_LOW,   8'h05, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_RED,       8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_GREEN,     8'h7f, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_CSR, CSR_BLUE,      8'h55, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hff, 8'h00, 8'hff, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h01, 8'h80, 8'hfe, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h7f, 8'hfe, 8'h01, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h33, 8'hcc, 8'h0f, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hf0, 8'h0f, 8'haa, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'h80, 8'h80, 8'h80, 1'b0, 24'h000000},
      '{ROW_LED, CSR_MODE,      8'h00, 8'hc3, 8'h3c, 8'h99, 1'b0, 24'h000000}
   };

   led_strip_meteor_serializer_top #(
      .LED_COUNT   (LED_COUNT),
      .TAIL_LENGTH (TAIL_LENGTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // colour of one channel at a given distance behind the head
   function automatic logic [7:0] dim(input logic [7:0] c, input int unsigned lag);
      return 8'(c - lag * (c / TAIL_LENGTH));
   endfunction

   // mirror a register write into the shadow settings
   function automatic void store_setting(input logic [CSR_IDX_W-1:0] index,
                                         input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_MODE:      eff_mode  = data[1:0];
         CSR_RED:       eff_red   = data;
         CSR_GREEN:     eff_green = data;
         CSR_BLUE:      eff_blue  = data;
         CSR_ZERO_HIGH: zero_high = data[5:0];
         CSR_ZERO_LOW:  zero_low  = data[5:0];
         CSR_ONE_HIGH:  one_high  = data[5:0];
         CSR_ONE_LOW:   one_low   = data[5:0];
         default: ;
      endcase
   endfunction

   // pick the colour sent for the current LED and advance the frame; 0 when dropped
   function automatic bit shade_led(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, output logic [23:0] grb,
                                    output bit last_led);
      int unsigned lag;
      grb = '0;
      last_led = 1'b0;
      if (eff_mode != MODE_BLINK && eff_mode != MODE_METEOR)
         return 1'b0;
      if (eff_mode == MODE_BLINK) begin
         grb = blink_on ? {eff_green, eff_red, eff_blue} : 24'h000000;
      end else if (led_pos <= head_pos && led_pos + TAIL_LENGTH - 1 >= head_pos) begin
         lag = head_pos - led_pos;
         grb = {dim(eff_green, lag), dim(eff_red, lag), dim(eff_blue, lag)};
      end else begin
         grb = {g, r, b};
      end
      last_led = (led_pos == LED_COUNT - 1);
      if (last_led) begin
         led_pos = 0;
         if (eff_mode == MODE_METEOR)
            head_pos = (head_pos + 1) % HEAD_SPAN;
         else
            blink_on = ~blink_on;
      end else begin
         led_pos++;
      end
      return 1'b1;
   endfunction

   // queue the 24 pulses of one LED, MSB of green first
   function automatic void queue_pulses(input logic [23:0] grb, input bit last_led);
      pulse_type p;
      for (int k = 0; k < BITS_PER_LED; k++) begin
         p.bit_value  = grb[BITS_PER_LED - 1 - k];
         p.high_slots = p.bit_value ? one_high : zero_high;
         p.low_slots  = p.bit_value ? one_low : zero_low;
         p.last_bit   = (k == BITS_PER_LED - 1);
         p.frame_end  = p.last_bit && last_led;
         pulse_queue.push_back(p);
      end
   endfunction

   // colour level biased towards the extremes
   function automatic logic [7:0] level();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // slot register data, upper bits random, zero and full scale now and then
   function automatic logic [7:0] slot_data();
      case ($urandom_range(0, 7))
         0:       return {2'($urandom), 6'd0};
         1:       return {2'($urandom), 6'd63};
         2:       return {2'($urandom), 6'd1};
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      store_setting(index, data);
   endtask

   // wait for every pulse to come back, then let dropped requests settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      csr_wr_en      <= 1'b0;
      while (pulse_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // offer one LED transaction, in bursts with random gaps between them
   task automatic send_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input bit typed, input logic [23:0] typed_grb);
      int unsigned gap;
      logic [23:0] grb;
      bit          last_led;
      csr_wr_en <= 1'b0;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = 64;
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
         end
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.bg_red   <= r;
      req_chan.bg_green <= g;
      req_chan.bg_blue  <= b;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      burst_left--;
      if (shade_led(r, g, b, grb, last_led)) begin
         queue_pulses(typed ? typed_grb : grb, last_led);
         lit_leds++;
      end
   endtask

   // receiver back-pressure: switch between randomly chosen stall styles
   initial begin
      flow_style_type style;
      int unsigned    left;
      int unsigned    tick;
      rsp_chan.ready = 1'b0;
      style = FLOW_FREE;
      left  = 0;
      tick  = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            style = flow_style_type'($urandom_range(0, 3));
            left  = $urandom_range(50, 300);
         end
         left--;
         tick++;
         case (style)
            FLOW_FREE:     rsp_chan.ready <= 1'b1;
            FLOW_SPARSE:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            FLOW_PERIODIC: rsp_chan.ready <= (tick % 5 != 0);
            default:       rsp_chan.ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // check each pulse transaction against the oldest expectation
   always @(posedge clock) begin
      pulse_type want;
      pulse_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.bit_value, rsp_chan.high_slots, rsp_chan.low_slots,
                 rsp_chan.last_bit, rsp_chan.frame_end};
         if (pulse_queue.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected pulse, expected none, got bit %0d high %0d low %0d last %0d frame_end %0d",
                     $time, got.bit_value, got.high_slots, got.low_slots,
                     got.last_bit, got.frame_end);
         end else begin
            want = pulse_queue.pop_front();
            if (got !== want) begin
               fail_count++;
               $display("%0t: pulse mismatch, expected bit %0d high %0d low %0d last %0d frame_end %0d",
                        $time, want.bit_value, want.high_slots, want.low_slots,
                        want.last_bit, want.frame_end);
               $display("%0t:                 got      bit %0d high %0d low %0d last %0d frame_end %0d",
                        $time, got.bit_value, got.high_slots, got.low_slots,
                        got.last_bit, got.frame_end);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [1:0]  code;
      int unsigned leds;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.bg_red   = '0;
      req_chan.bg_green = '0;
      req_chan.bg_blue  = '0;
      eff_mode   = MODE_RESET;
      eff_red    = '0;
      eff_green  = '0;
      eff_blue   = '0;
      zero_high  = ZERO_HIGH_RESET;
      zero_low   = ZERO_LOW_RESET;
      one_high   = ONE_HIGH_RESET;
      one_low    = ONE_LOW_RESET;
      led_pos    = 0;
      head_pos   = 0;
      blink_on   = 1'b0;
      fail_count   = 0;
      burst_left   = 0;
      lit_leds     = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table; settle before any write that follows traffic
      for (int i = 0; i < $size(script); i++) begin
         if (script[i].kind == ROW_CSR) begin
            if (i != 0 && script[i-1].kind == ROW_LED)
               drain();
            write_csr(script[i].index, script[i].data);
         end else begin
            send_led(script[i].bg_red, script[i].bg_green, script[i].bg_blue,
                     script[i].typed, script[i].grb);
         end
      end

      // random phases: new settings while idle, frames left mid-way across mode changes
      lit_leds = 0;
      while (lit_leds < RANDOM_LEDS) begin
         drain();
         case ($urandom_range(0, 9))
            0:          code = MODE_OFF;
            1:          code = MODE_SPARE;
            2, 3, 4:    code = MODE_BLINK;
            default:    code = MODE_METEOR;
         endcase
         write_csr(CSR_MODE, {6'($urandom), code});
         if ($urandom_range(0, 2) != 0) write_csr(CSR_RED, level());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_GREEN, level());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_BLUE, level());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ZERO_HIGH, slot_data());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ZERO_LOW, slot_data());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ONE_HIGH, slot_data());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ONE_LOW, slot_data());
         leds = $urandom_range(8, 64);
         repeat (leds) send_led(level(), level(), level(), 1'b0, '0);
      end

      // wait for the last pulses, then watch for strays
      drain();
      repeat (4 * BITS_PER_LED) @(posedge clock);
      if (fail_count == 0)
         $display("led_strip_meteor_serializer_top regression: pass");
      else
         $display("led_strip_meteor_serializer_top regression: fail");
      $finish;
   end

   // hard stop on a hang
   initial begin
      #4_000_000;
      $display("led_strip_meteor_serializer_top regression: fail");
      $finish;
   end

endmodule
